// ===== rtl/rssc_pkg.sv =====
// ----------------------------------------------------------------------------
// Ray/sphere character shader package
// Shared constants and register codes for the shader pipeline.
// ----------------------------------------------------------------------------
package rssc_pkg;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_FRAME_WIDTH  = 3'd0,
      CSR_FRAME_HEIGHT = 3'd1,
      CSR_CENTER_X     = 3'd2,
      CSR_CENTER_Y     = 3'd3,
      CSR_CENTER_Z     = 3'd4,
      CSR_SPHERE_SIZE  = 3'd5,
      CSR_NEAR_BAND    = 3'd6,
      CSR_FAR_BAND     = 3'd7
   } csr_index_type;

   // Output glyph codes (ASCII).
   localparam logic [6:0] GLYPH_NEAR  = 7'd35;
   localparam logic [6:0] GLYPH_MID   = 7'd43;
   localparam logic [6:0] GLYPH_FAR   = 7'd46;
   localparam logic [6:0] GLYPH_SPACE = 7'd32;

   // Field and datapath widths fixed by the Q8.8 formats.
   localparam int CENTER_W = 16;
   localparam int SIZE_W   = 15;
   localparam int DIST_W   = 15;
   localparam int GLYPH_W  = 7;
   localparam int MAG_W    = 15;   // direction magnitude after prescale
   localparam int SQ_W     = 30;   // square of one magnitude
   localparam int NORM_W   = 32;   // sum of three squares
   localparam int PROJ_W   = 19;   // projection length, signed
   localparam int K_W      = 34;   // |C|^2 - r^2, signed
   localparam int DISC_W   = 38;   // discriminant, signed
   localparam int ROOT_IN_W = 35;  // nonnegative discriminant
   localparam int ROOT_W   = 18;   // its square root

   localparam int PRESCALE_LIMIT = 32768;
   localparam logic [DIST_W-1:0] DIST_MAX = 15'd32767;

   // Reset values of the configuration registers.
   localparam int RST_FRAME_WIDTH  = 80;
   localparam int RST_FRAME_HEIGHT = 24;
   localparam logic [CENTER_W-1:0] RST_CENTER_Z = 16'd1536;
   localparam logic [SIZE_W-1:0] RST_SPHERE_SIZE = 15'd512;
   localparam logic [SIZE_W-1:0] RST_NEAR_BAND   = 15'd1280;
   localparam logic [SIZE_W-1:0] RST_FAR_BAND    = 15'd1408;

endpackage

// ===== rtl/rssc_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Computes floor(a * 2^(Q_W-1) / n) for a <= n, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rssc_div #(
   parameter int A_W  = 30,
   parameter int N_W  = 32,
   parameter int Q_W  = 17,
   parameter int SB_W = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [A_W-1:0]  in_a,
   input  logic [N_W-1:0]  in_n,
   input  logic [SB_W-1:0] in_sb,
   output logic            out_valid,
   output logic [Q_W-1:0]  out_q,
   output logic [SB_W-1:0] out_sb
);

   logic [Q_W-1:0]  valid_ff;
   logic [N_W:0]    rem_ff [Q_W];
   logic [N_W-1:0]  n_ff   [Q_W];
   logic [Q_W-1:0]  q_ff   [Q_W];
   logic [SB_W-1:0] sb_ff  [Q_W];

   // Valid bits follow the items down the stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[Q_W-2:0], in_valid};
      end
   end

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      logic [N_W:0]    rem_try;
      logic [N_W:0]    rem_in;
      logic [Q_W-1:0]  q_in;
      logic [N_W-1:0]  n_cur;
      logic [SB_W-1:0] sb_cur;

      // Shift the partial remainder in, then try one subtraction.
      always_comb begin
         if (k == 0) begin
            rem_try = (N_W+1)'(in_a);
            q_in    = '0;
            n_cur   = in_n;
            sb_cur  = in_sb;
         end else begin
            rem_try = {rem_ff[k-1][N_W-1:0], 1'b0};
            q_in    = q_ff[k-1];
            n_cur   = n_ff[k-1];
            sb_cur  = sb_ff[k-1];
         end
         rem_in = rem_try;
         if (rem_try >= {1'b0, n_cur}) begin
            rem_in          = rem_try - {1'b0, n_cur};
            q_in[Q_W-1-k]   = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            q_ff[k]   <= q_in;
            n_ff[k]   <= n_cur;
            sb_ff[k]  <= sb_cur;
         end
      end
   end

   assign out_valid = valid_ff[Q_W-1];
   assign out_q     = q_ff[Q_W-1];
   assign out_sb    = sb_ff[Q_W-1];

endmodule

// ===== rtl/rssc_sqrt.sv =====
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Computes floor(sqrt(x)) one result bit per stage.
// ----------------------------------------------------------------------------
module rssc_sqrt #(
   parameter int W    = 17,
   parameter int SB_W = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [W-1:0]          in_x,
   input  logic [SB_W-1:0]       in_sb,
   output logic                  out_valid,
   output logic [(W+1)/2-1:0]    out_root,
   output logic [SB_W-1:0]       out_sb
);

   localparam int RW = (W + 1) / 2;

   logic [RW-1:0]   valid_ff;
   logic [W-1:0]    rem_ff [RW];
   logic [RW-1:0]   res_ff [RW];
   logic [SB_W-1:0] sb_ff  [RW];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[RW-2:0], in_valid};
      end
   end

   for (genvar k = 0; k < RW; k++) begin : g_stage
      localparam int B = RW - 1 - k;
      logic [W-1:0]    rem_cur;
      logic [RW-1:0]   res_cur;
      logic [SB_W-1:0] sb_cur;
      logic [W+1:0]    trial;
      logic [W-1:0]    rem_in;
      logic [RW-1:0]   res_in;

      // The remainder holds x - res^2; adding bit B costs res*2^(B+1) + 4^B.
      always_comb begin
         if (k == 0) begin
            rem_cur = in_x;
            res_cur = '0;
            sb_cur  = in_sb;
         end else begin
            rem_cur = rem_ff[k-1];
            res_cur = res_ff[k-1];
            sb_cur  = sb_ff[k-1];
         end
         trial  = ((W+2)'(res_cur) << (B + 1)) | ((W+2)'(1) << (2 * B));
         rem_in = rem_cur;
         res_in = res_cur;
         if ((W+2)'(rem_cur) >= trial) begin
            rem_in    = W'((W+2)'(rem_cur) - trial);
            res_in[B] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            res_ff[k] <= res_in;
            sb_ff[k]  <= sb_cur;
         end
      end
   end

   assign out_valid = valid_ff[RW-1];
   assign out_root  = res_ff[RW-1];
   assign out_sb    = sb_ff[RW-1];

endmodule

// ===== rtl/rssc_dir.sv =====
// ----------------------------------------------------------------------------
// Ray direction front end
// Builds the integer direction, prescales it and forms the squared lengths.
// ----------------------------------------------------------------------------
module rssc_dir #(
   parameter int P = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [P-1:0]               column,
   input  logic [P-1:0]               row,
   input  logic [P-1:0]               frame_width,
   input  logic [P-1:0]               frame_height,
   output logic                       out_valid,
   output logic [rssc_pkg::SQ_W-1:0]  out_sq [3],
   output logic [rssc_pkg::NORM_W-1:0] out_norm,
   output logic [2:0]                 out_neg
);
   import rssc_pkg::*;

   localparam int MW   = P + 2;
   localparam int SMAX = (MW > MAG_W) ? MW - MAG_W : 0;
   localparam int SH_W = (SMAX > 0) ? $clog2(SMAX + 1) : 1;

   logic [3:0]          valid_ff;
   logic signed [P+2:0] raw_ff [3];
   logic [MAG_W-1:0]    mag_ff [3];
   logic [2:0]          neg_ff, neg2_ff, neg3_ff;
   logic [SQ_W-1:0]     sq_ff  [3];
   logic [SQ_W-1:0]     sq2_ff [3];
   logic [NORM_W-1:0]   norm_ff;

   logic [P-1:0]        height;
   logic signed [P+2:0] raw_in [3];
   logic [MW-1:0]       mag    [3];
   logic [MW-1:0]       mag_or;
   logic [SH_W-1:0]     sh;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   // Stage one: direction (2c - W, 2H - 4r, 2H), zero height taken as one.
   always_comb begin
      height    = (frame_height == '0) ? P'(1) : frame_height;
      raw_in[0] = $signed({2'b00, column, 1'b0}) - $signed({3'b000, frame_width});
      raw_in[1] = $signed({2'b00, height, 1'b0}) - $signed({1'b0, row, 2'b00});
      raw_in[2] = $signed({2'b00, height, 1'b0});
   end

   // Stage two: magnitudes, shifted together until the largest fits.
   always_comb begin
      mag_or = '0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = raw_ff[i][P+2] ? MW'(-raw_ff[i]) : MW'(raw_ff[i]);
         mag_or = mag_or | mag[i];
      end
      sh = '0;
      for (int s = SMAX; s >= 0; s--) begin
         if ((mag_or >> s) < PRESCALE_LIMIT) begin
            sh = SH_W'(s);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            raw_ff[i] <= raw_in[i];
            mag_ff[i] <= MAG_W'(mag[i] >> sh);
            sq_ff[i]  <= SQ_W'(mag_ff[i]) * SQ_W'(mag_ff[i]);
            sq2_ff[i] <= sq_ff[i];
            neg_ff[i] <= raw_ff[i][P+2];
         end
         neg2_ff <= neg_ff;
         neg3_ff <= neg2_ff;
         norm_ff <= NORM_W'(sq_ff[0]) + NORM_W'(sq_ff[1]) + NORM_W'(sq_ff[2]);
      end
   end

   assign out_valid = valid_ff[3];
   assign out_sq    = sq2_ff;
   assign out_norm  = norm_ff;
   assign out_neg   = neg3_ff;

endmodule

// ===== rtl/rssc_hit.sv =====
// ----------------------------------------------------------------------------
// Sphere hit back end
// Projects the center on the ray, solves for the nearer hit and shades it.
// ----------------------------------------------------------------------------
module rssc_hit #(
   parameter int F = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic signed [F+1:0]                 dir [3],
   input  logic signed [rssc_pkg::CENTER_W-1:0] center [3],
   input  logic signed [rssc_pkg::K_W-1:0]     k_term,
   input  logic [rssc_pkg::SIZE_W-1:0]         near_band,
   input  logic [rssc_pkg::SIZE_W-1:0]         far_band,
   output logic                                out_valid,
   output logic [rssc_pkg::GLYPH_W-1:0]        out_glyph,
   output logic                                out_hit,
   output logic [rssc_pkg::DIST_W-1:0]         out_dist
);
   import rssc_pkg::*;

   localparam int PR_W = CENTER_W + F + 2;

   logic [3:0]                valid_ff;
   logic signed [PR_W-1:0]    prod_ff [3];
   logic signed [PROJ_W-1:0]  p_ff, p2_ff, p3_ff;
   logic [ROOT_IN_W:0]        pp_ff;
   logic [ROOT_IN_W-1:0]      rad_ff;
   logic                      neg_ff;
   logic signed [PR_W+1:0]    dot;
   logic signed [DISC_W-1:0]  disc;

   logic                      sq_valid;
   logic [ROOT_W-1:0]         root;
   logic [PROJ_W:0]           sq_sb;

   logic signed [PROJ_W:0]    near_dist;
   logic                      hit_in;
   logic [GLYPH_W-1:0]        glyph_in;
   logic                      valid_o_ff, hit_ff;
   logic [GLYPH_W-1:0]        glyph_ff;
   logic [DIST_W-1:0]         dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   // Projection P = floor(C . d / 2^F), then P^2 and the discriminant.
   always_comb begin
      dot  = (PR_W+2)'(prod_ff[0]) + (PR_W+2)'(prod_ff[1]) + (PR_W+2)'(prod_ff[2]);
      disc = $signed({2'b00, pp_ff}) - DISC_W'(k_term);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            prod_ff[i] <= PR_W'(center[i]) * PR_W'(dir[i]);
         end
         p_ff   <= PROJ_W'(dot >>> F);
         pp_ff  <= (ROOT_IN_W+1)'(p_ff) * (ROOT_IN_W+1)'(p_ff);
         p2_ff  <= p_ff;
         neg_ff <= disc[DISC_W-1];
         rad_ff <= disc[DISC_W-1] ? '0 : disc[ROOT_IN_W-1:0];
         p3_ff  <= p2_ff;
      end
   end

   rssc_sqrt #(
      .W    (ROOT_IN_W),
      .SB_W (PROJ_W + 1)
   ) u_root (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (valid_ff[3]),
      .in_x      (rad_ff),
      .in_sb     ({neg_ff, p3_ff}),
      .out_valid (sq_valid),
      .out_root  (root),
      .out_sb    (sq_sb)
   );

   // Nearer distance, hit test and glyph bands on the unsaturated value.
   always_comb begin
      near_dist = $signed({sq_sb[PROJ_W-1], sq_sb[PROJ_W-1:0]})
                  - $signed({2'b00, root});
      hit_in    = !sq_sb[PROJ_W] && (near_dist > 0);
      glyph_in  = GLYPH_SPACE;
      if (hit_in) begin
         priority if (near_dist > $signed({5'b0, far_band})) begin
            glyph_in = GLYPH_FAR;
         end else if (near_dist > $signed({5'b0, near_band})) begin
            glyph_in = GLYPH_MID;
         end else begin
            glyph_in = GLYPH_NEAR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_o_ff <= 1'b0;
      end else if (en) begin
         valid_o_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         glyph_ff <= glyph_in;
         hit_ff   <= hit_in;
         if (!hit_in) begin
            dist_ff <= '0;
         end else if (near_dist > $signed({5'b0, DIST_MAX})) begin
            dist_ff <= DIST_MAX;
         end else begin
            dist_ff <= near_dist[DIST_W-1:0];
         end
      end
   end

   assign out_valid = valid_o_ff;
   assign out_glyph = glyph_ff;
   assign out_hit   = hit_ff;
   assign out_dist  = dist_ff;

endmodule

// ===== rtl/ray_sphere_char_shader_core.sv =====
// ----------------------------------------------------------------------------
// Ray/sphere character shader core
// Casts one camera ray per character cell and shades the sphere it meets.
// ----------------------------------------------------------------------------
// Takes one pixel per cycle unless stalled and returns one result per pixel,
// in order. Each item's path to the output register runs through the
// bit-per-stage divider of the normalization, its square root and the
// 18-stage root of the discriminant. While the output is stalled the
// pipeline keeps moving until a result has to wait; that result goes into
// a skid register, and from then on the pipeline and the input stall until
// the output is taken. Configuration registers feed the stages directly,
// so a write can also reach items already in flight.
module ray_sphere_char_shader_core #(
   parameter int PIXEL_BITS = 10,
   parameter int FRAC_BITS  = 8
) (
   input  logic clock,
   input  logic reset,

   input  logic                           req_tvalid,
   output logic                           req_tready,
   // column, row
   input  logic [((2*PIXEL_BITS+7)/8)*8-1:0] req_tdata,

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // glyph, distance
   output logic [23:0] rsp_tdata,
   // hit
   output logic        rsp_tuser,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import rssc_pkg::*;

   localparam int P   = PIXEL_BITS;
   localparam int F   = FRAC_BITS;
   localparam int Q_W = 2 * F + 1;
   localparam int D_W = F + 1;
   localparam int RES_W = GLYPH_W + 1 + DIST_W;

   // Configuration registers.
   logic [P-1:0]               frame_width_ff, frame_height_ff;
   logic signed [CENTER_W-1:0] center_ff [3];
   logic [SIZE_W-1:0]          size_ff, near_ff, far_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= P'(RST_FRAME_WIDTH);
         frame_height_ff <= P'(RST_FRAME_HEIGHT);
         center_ff[0]    <= '0;
         center_ff[1]    <= '0;
         center_ff[2]    <= RST_CENTER_Z;
         size_ff         <= RST_SPHERE_SIZE;
         near_ff         <= RST_NEAR_BAND;
         far_ff          <= RST_FAR_BAND;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  frame_width_ff  <= P'(csr_data);
            CSR_FRAME_HEIGHT: frame_height_ff <= P'(csr_data);
            CSR_CENTER_X:     center_ff[0]    <= csr_data;
            CSR_CENTER_Y:     center_ff[1]    <= csr_data;
            CSR_CENTER_Z:     center_ff[2]    <= csr_data;
            CSR_SPHERE_SIZE:  size_ff         <= csr_data[SIZE_W-1:0];
            CSR_NEAR_BAND:    near_ff         <= csr_data[SIZE_W-1:0];
            CSR_FAR_BAND:     far_ff          <= csr_data[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // K = |C|^2 - r^2, recomputed continuously from the registers.
   logic [NORM_W-1:0]       csq_ff [3];
   logic [NORM_W-1:0]       rsq_ff;
   logic signed [K_W-1:0]   k_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         csq_ff[i] <= NORM_W'(center_ff[i]) * NORM_W'(center_ff[i]);
      end
      rsq_ff <= NORM_W'(size_ff) * NORM_W'(size_ff);
      k_ff   <= $signed(K_W'(csq_ff[0]) + K_W'(csq_ff[1]) + K_W'(csq_ff[2]))
                - $signed(K_W'(rsq_ff));
   end

   // The whole pipeline advances unless the skid register is occupied.
   logic skid_valid_ff;
   logic en;

   assign en         = !skid_valid_ff;
   assign req_tready = en;

   // Direction and squared lengths.
   logic              dir_valid;
   logic [SQ_W-1:0]   dir_sq [3];
   logic [NORM_W-1:0] dir_norm;
   logic [2:0]        dir_neg;

   rssc_dir #(
      .P (P)
   ) u_dir (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req_tvalid),
      .column       (req_tdata[P-1:0]),
      .row          (req_tdata[2*P-1:P]),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .out_valid    (dir_valid),
      .out_sq       (dir_sq),
      .out_norm     (dir_norm),
      .out_neg      (dir_neg)
   );

   // Normalization lanes: divide, take the root and restore the sign.
   logic [2:0]               div_valid, rt_valid;
   logic [Q_W-1:0]           quot [3];
   logic [2:0]               div_neg, rt_neg;
   logic [D_W-1:0]           mag_d [3];
   logic signed [D_W:0]      dir_d [3];

   for (genvar i = 0; i < 3; i++) begin : g_lane
      rssc_div #(
         .A_W  (SQ_W),
         .N_W  (NORM_W),
         .Q_W  (Q_W),
         .SB_W (1)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (dir_valid),
         .in_a      (dir_sq[i]),
         .in_n      (dir_norm),
         .in_sb     (dir_neg[i]),
         .out_valid (div_valid[i]),
         .out_q     (quot[i]),
         .out_sb    (div_neg[i])
      );

      rssc_sqrt #(
         .W    (Q_W),
         .SB_W (1)
      ) u_sqrt (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (div_valid[i]),
         .in_x      (quot[i]),
         .in_sb     (div_neg[i]),
         .out_valid (rt_valid[i]),
         .out_root  (mag_d[i]),
         .out_sb    (rt_neg[i])
      );

      assign dir_d[i] = rt_neg[i] ? -$signed({1'b0, mag_d[i]}) : $signed({1'b0, mag_d[i]});
   end

   // Hit test and shading.
   logic                hit_valid;
   logic [GLYPH_W-1:0]  hit_glyph;
   logic                hit_flag;
   logic [DIST_W-1:0]   hit_dist;

   rssc_hit #(
      .F (F)
   ) u_hit (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (&rt_valid),
      .dir       (dir_d),
      .center    (center_ff),
      .k_term    (k_ff),
      .near_band (near_ff),
      .far_band  (far_ff),
      .out_valid (hit_valid),
      .out_glyph (hit_glyph),
      .out_hit   (hit_flag),
      .out_dist  (hit_dist)
   );

   // Output register with one skid entry behind it.
   logic             out_valid_ff;
   logic [RES_W-1:0] out_data_ff, skid_data_ff, pipe_data;
   logic             out_busy;

   assign pipe_data = {hit_flag, hit_dist, hit_glyph};
   assign out_busy  = out_valid_ff && !rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         priority if (out_busy) begin
            if (en && hit_valid) begin
               skid_valid_ff <= 1'b1;
            end
         end else if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= hit_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      priority if (out_busy) begin
         if (en && hit_valid) begin
            skid_data_ff <= pipe_data;
         end
      end else if (skid_valid_ff) begin
         out_data_ff <= skid_data_ff;
      end else begin
         out_data_ff <= pipe_data;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_data_ff[RES_W-2:0]};
   assign rsp_tuser  = out_data_ff[RES_W-1];

endmodule

// ===== rtl/rssc_checker.sv =====
// ----------------------------------------------------------------------------
// Ray/sphere character shader port checker
// Watches the result port of the core for consistent shading results.
// ----------------------------------------------------------------------------
module rssc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser
);
   import rssc_pkg::*;

   // A stalled result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // A stalled result does not change.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // A miss carries a blank glyph and a zero distance.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[6:0] == GLYPH_SPACE
                                   && rsp_tdata[21:7] == '0)
      else $error("miss with glyph or distance");

   // A hit carries a shading glyph and a positive distance.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata[6:0] == GLYPH_NEAR
                                   || rsp_tdata[6:0] == GLYPH_MID
                                   || rsp_tdata[6:0] == GLYPH_FAR)
                                  && rsp_tdata[21:7] != '0)
      else $error("hit without glyph or distance");

endmodule

bind ray_sphere_char_shader_core rssc_checker u_rssc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
